[rtl/core/gbn_pkg.sv]
package gbn_pkg;

    // input selector codes
    localparam logic [1:0] MODE_MSG     = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CORRUPT = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_STALE   = 2'd3;

    localparam int BufferDepthDefault = 64;
    localparam int MaxWindowDefault   = 32;
    localparam int ResultCap          = 32;

    localparam int WinW = 6;
    localparam logic [WinW-1:0] WINDOW_RESET = 6'd7;

    localparam int SeqW     = 32;
    localparam int CksW     = 13;
    localparam int PayloadW = 160;

    localparam int InDataW   = 256;
    localparam int InUserW   = 2;
    localparam int OutDataW  = 208;
    localparam int OutUserW  = 3;

    typedef struct packed {
        logic capture;
        logic eval;
        logic rd_send;
        logic rd_res;
        logic emit_pkt;
        logic emit_empty;
    } gbn_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       corrupt;
        logic       stale;
        logic       none_out;
        logic       send_ok;
        logic       more;
        logic       out_free;
    } gbn_sts_t;

    // byte sum of one 32-bit word
    function automatic logic [9:0] sum4(input logic [31:0] w);
        logic [9:0] s;
        s = 10'(w[7:0]) + 10'(w[15:8]) + 10'(w[23:16]) + 10'(w[31:24]);
        return s;
    endfunction

endpackage

[rtl/core/gbn_ctrl.sv]
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  gbn_sts_t sts,
    output gbn_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_SEND   = 3'd2;
    localparam logic [2:0] ST_RESEND = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                unique case (sts.mode)
                    MODE_MSG:     state_next = sts.full ? ST_EMPTY : ST_SEND;
                    MODE_ACK:     state_next = (sts.corrupt || sts.stale) ? ST_EMPTY : ST_SEND;
                    MODE_TIMEOUT: state_next = sts.none_out ? ST_EMPTY : ST_RESEND;
                    default:      state_next = ST_EMPTY;
                endcase
            end
            ST_SEND: begin
                if (sts.send_ok) begin
                    cmd.rd_send = 1'b1;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_EMPTY;
                end
            end
            ST_RESEND: begin
                cmd.rd_res = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_pkt = 1'b1;
                    if (!sts.more) begin
                        state_next = ST_IDLE;
                    end else if (sts.mode == MODE_TIMEOUT) begin
                        state_next = ST_RESEND;
                    end else begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_EMPTY: begin
                if (sts.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/gbn_dp.sv]
module gbn_dp
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH = BufferDepthDefault,
    parameter int MAX_WINDOW   = MaxWindowDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [WinW-1:0]     window_size,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic [InUserW-1:0]  s_tuser,
    input  gbn_cmd_t            cmd,
    output gbn_sts_t            sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    output logic [OutUserW-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int SW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [SW:0] DEPTH_W = (SW+1)'(BUFFER_DEPTH);
    localparam logic [SW:0] WRAP_ADJ = (SW+1)'(64'h1_0000_0000 % 64'(BUFFER_DEPTH));
    localparam int WCAP = (MAX_WINDOW < ResultCap) ? MAX_WINDOW : ResultCap;
    localparam logic [WinW-1:0] WCAP_W = WinW'(WCAP);

    // slot of seq+k from slot of seq, k never above the depth
    // a carry out of 32 bits drops 2^32 mod depth from the slot
    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] slot,
                                               input logic [31:0] seq,
                                               input logic [31:0] k);
        logic [32:0] wide;
        logic [SW:0] s;
        wide = {1'b0, seq} + {1'b0, k};
        s    = {1'b0, slot} + k[SW:0];
        if (s >= DEPTH_W) s = s - DEPTH_W;
        if (wide[32]) begin
            if (s >= WRAP_ADJ) begin
                s = s - WRAP_ADJ;
            end else begin
                s = s + DEPTH_W - WRAP_ADJ;
            end
        end
        return s[SW-1:0];
    endfunction

    // captured item
    logic [1:0]          mode_reg;
    logic [PayloadW-1:0] pay_reg;
    logic [31:0]         seqw_reg, ackn_reg, ackcks_reg;

    // window state
    logic [31:0]   base_reg, nts_reg, tail_reg, res_seq_reg, pkt_seq_reg;
    logic [SW-1:0] base_slot_reg, nts_slot_reg, tail_slot_reg, res_slot_reg;
    logic [5:0]    res_cnt_reg;
    logic          start_pend_reg, stop_pend_reg;
    logic [1:0]    stat_reg;

    logic [PayloadW-1:0] mem [BUFFER_DEPTH];
    logic [PayloadW-1:0] rd_data_reg;
    logic [SW-1:0]       rd_addr;

    // output beat register
    logic                m_valid_reg, m_valid_next;
    logic [OutDataW-1:0] m_data_reg;
    logic [OutUserW-1:0] m_user_reg;
    logic                m_last_reg;

    logic [WinW-1:0] win;
    logic [31:0]     nb, adv, outst, occ;
    logic [12:0]     ack_sum, pkt_cks;
    logic            full, corrupt, stale, send_ok, ack_stop, more;
    logic [5:0]      res_load;

    always_comb begin
        if (window_size == '0) begin
            win = WinW'(1);
        end else if (window_size > WCAP_W) begin
            win = WCAP_W;
        end else begin
            win = window_size;
        end
    end

    assign occ   = tail_reg - base_reg;
    assign outst = nts_reg - base_reg;
    assign nb    = ackn_reg + 32'd1;
    assign adv   = nb - base_reg;
    assign full  = (occ >= 32'(BUFFER_DEPTH));

    assign ack_sum = 13'(sum4(seqw_reg)) + 13'(sum4(ackn_reg))
                   + 13'(sum4(pay_reg[31:0])) + 13'(sum4(pay_reg[63:32]))
                   + 13'(sum4(pay_reg[95:64])) + 13'(sum4(pay_reg[127:96]))
                   + 13'(sum4(pay_reg[159:128]));
    assign corrupt  = (ackcks_reg != 32'(ack_sum));
    assign stale    = (adv == 32'd0) || (adv > outst);
    assign ack_stop = (nb == nts_reg) && (nts_reg == tail_reg);

    assign send_ok  = (nts_reg != tail_reg) && (outst < 32'(win));
    assign more     = (mode_reg == MODE_TIMEOUT) ? (res_cnt_reg != '0) : send_ok;
    assign res_load = (outst > 32'(ResultCap)) ? 6'(ResultCap) : outst[5:0];

    assign pkt_cks = 13'(sum4(pkt_seq_reg))
                   + 13'(sum4(rd_data_reg[31:0])) + 13'(sum4(rd_data_reg[63:32]))
                   + 13'(sum4(rd_data_reg[95:64])) + 13'(sum4(rd_data_reg[127:96]))
                   + 13'(sum4(rd_data_reg[159:128]));

    always_comb begin
        sts          = '0;
        sts.mode     = mode_reg;
        sts.full     = full;
        sts.corrupt  = corrupt;
        sts.stale    = stale;
        sts.none_out = (outst == 32'd0);
        sts.send_ok  = send_ok;
        sts.more     = more;
        sts.out_free = !m_valid_reg || m_tready;
    end

    assign rd_addr = cmd.rd_res ? res_slot_reg : nts_slot_reg;

    // payload store
    always_ff @(posedge aclk) begin
        if (cmd.eval && (mode_reg == MODE_MSG) && !full) begin
            mem[tail_slot_reg] <= pay_reg;
        end
        if (cmd.rd_send || cmd.rd_res) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // captured item and packet payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_tuser;
            pay_reg    <= s_tdata[159:0];
            seqw_reg   <= s_tdata[191:160];
            ackn_reg   <= s_tdata[223:192];
            ackcks_reg <= s_tdata[255:224];
        end
        if (cmd.rd_send) begin
            pkt_seq_reg <= nts_reg;
        end else if (cmd.rd_res) begin
            pkt_seq_reg <= res_seq_reg;
        end
        if (cmd.emit_pkt) begin
            m_data_reg <= {1'b0, stop_pend_reg, start_pend_reg, rd_data_reg, pkt_cks,
                           pkt_seq_reg};
            m_user_reg <= {stat_reg, 1'b1};
            m_last_reg <= !more;
        end else if (cmd.emit_empty) begin
            m_data_reg <= {1'b0, stop_pend_reg, start_pend_reg,
                           (OutDataW-3)'(0)};
            m_user_reg <= {stat_reg, 1'b0};
            m_last_reg <= 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit_pkt || cmd.emit_empty) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            nts_reg        <= '0;
            tail_reg       <= '0;
            base_slot_reg  <= '0;
            nts_slot_reg   <= '0;
            tail_slot_reg  <= '0;
            res_seq_reg    <= '0;
            res_slot_reg   <= '0;
            res_cnt_reg    <= '0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
            stat_reg       <= STAT_OK;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.eval) begin
                unique case (mode_reg)
                    MODE_MSG: begin
                        stop_pend_reg <= 1'b0;
                        if (full) begin
                            stat_reg       <= STAT_FULL;
                            start_pend_reg <= 1'b0;
                        end else begin
                            stat_reg       <= STAT_OK;
                            tail_reg       <= tail_reg + 32'd1;
                            tail_slot_reg  <= slot_add(tail_slot_reg, tail_reg, 32'd1);
                            start_pend_reg <= (base_reg == nts_reg);
                        end
                    end
                    MODE_ACK: begin
                        if (corrupt) begin
                            stat_reg       <= STAT_CORRUPT;
                            start_pend_reg <= 1'b0;
                            stop_pend_reg  <= 1'b0;
                        end else if (stale) begin
                            stat_reg       <= STAT_STALE;
                            start_pend_reg <= 1'b0;
                            stop_pend_reg  <= 1'b0;
                        end else begin
                            stat_reg       <= STAT_OK;
                            base_reg       <= nb;
                            base_slot_reg  <= slot_add(base_slot_reg, base_reg, adv);
                            stop_pend_reg  <= ack_stop;
                            start_pend_reg <= !ack_stop;
                        end
                    end
                    MODE_TIMEOUT: begin
                        stat_reg       <= STAT_OK;
                        res_seq_reg    <= base_reg;
                        res_slot_reg   <= base_slot_reg;
                        res_cnt_reg    <= res_load;
                        start_pend_reg <= (outst != 32'd0);
                        stop_pend_reg  <= 1'b0;
                    end
                    default: begin
                        stat_reg       <= STAT_OK;
                        start_pend_reg <= 1'b0;
                        stop_pend_reg  <= 1'b0;
                    end
                endcase
            end
            if (cmd.rd_send) begin
                nts_reg      <= nts_reg + 32'd1;
                nts_slot_reg <= slot_add(nts_slot_reg, nts_reg, 32'd1);
            end
            if (cmd.rd_res) begin
                res_seq_reg  <= res_seq_reg + 32'd1;
                res_slot_reg <= slot_add(res_slot_reg, res_seq_reg, 32'd1);
                res_cnt_reg  <= res_cnt_reg - 6'd1;
            end
            if (cmd.emit_pkt || cmd.emit_empty) begin
                start_pend_reg <= 1'b0;
                stop_pend_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        occ <= 32'(BUFFER_DEPTH))
        else $error("buffer occupancy beyond depth");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        outst <= occ)
        else $error("next to send outside base and tail");

    a_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        outst <= 32'(ResultCap))
        else $error("more packets in flight than the largest window");

    a_resend_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_res |-> res_cnt_reg != '0)
        else $error("resend issued with no packet left");

endmodule

[rtl/core/go_back_n_sender_top.sv]
// path from accept to first packet beat: decide, store read, output register
// packet beats: each takes a store read, then a checksum and output register step; a held-off sink stalls that step
// one item at a time: no new item is accepted until the last beat of the current one is emitted;
// a message or good ack that finds the window shut passes the send state, then a lone status beat
// reset: synchronous active low, window cleared to empty, window size back to 7
// payload store is not cleared, only written slots are ever read
module go_back_n_sender_top
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH = BufferDepthDefault,
    parameter int MAX_WINDOW   = MaxWindowDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    // window size register write
    input  logic                cfg_wr_en,
    input  logic [WinW-1:0]     cfg_wr_data,
    // incoming item beat
    input  logic                s_tvalid,
    output logic                s_tready,
    // payload_high, payload_middle, payload_low, pkt_seq_word, ack_number, ack_checksum
    input  logic [InDataW-1:0]  s_tdata,
    // mode
    input  logic [InUserW-1:0]  s_tuser,
    // result beat
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_seq, out_checksum, out_payload_high, out_payload_middle, out_payload_low,
    // timer_start, timer_stop, one zero pad bit
    output logic [OutDataW-1:0] m_tdata,
    // has_packet, status
    output logic [OutUserW-1:0] m_tuser,
    // last
    output logic                m_tlast
);

    // window size register, to be written only between items; the block itself does not enforce this
    logic [WinW-1:0] window_size_reg;

    gbn_cmd_t cmd;
    gbn_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_size_reg <= cfg_wr_data;
        end
    end

    // sequencer: one item at a time, walks the send or resend loop
    gbn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window pointers, payload store, checksums and the output register
    gbn_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .window_size (window_size_reg),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
